@@ hw/rtl/utc_calendar_to_epoch_seconds_defines.svh @@
// ----------------------------------------------------------------------------
// UTC calendar to epoch seconds: assertion macros
// Shared property templates for the checker attached to the top level.
// ----------------------------------------------------------------------------
`ifndef UTC_CALENDAR_TO_EPOCH_SECONDS_DEFINES_SVH
`define UTC_CALENDAR_TO_EPOCH_SECONDS_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define UCTE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define UCTE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ucte_pkg.sv @@
// ----------------------------------------------------------------------------
// UTC calendar to epoch seconds: package
// Field widths, calendar constants, reciprocal constants and stage control.
// ----------------------------------------------------------------------------
package ucte_pkg;

  // Port field widths
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 12;
  localparam int DAY_W   = 6;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int EPOCH_W = 39;

  // Internal widths
  localparam int YR_W   = 15;  // normalized year, signed
  localparam int ROLL_W = 9;   // floor(month / 12), signed
  localparam int MON_W  = 4;   // normalized month 0..11
  localparam int X_W    = YR_W - 2;  // floor((year - 1) / 4), signed
  localparam int PROD25_W = 26;
  localparam int Q25_W  = 9;   // floor((year - 1) / 100), signed
  localparam int DAYS_W = 24;  // days since epoch, signed
  localparam int TOD_W  = 17;  // seconds from hour, minute, second
  localparam int CUM_W  = 9;

  // Calendar constants
  localparam logic [YR_W-1:0]   YEAR_ORIGIN  = YR_W'(1900);
  localparam logic [DAYS_W-1:0] DAYS_PER_YR  = DAYS_W'(365);
  // Day count from year 1 to the epoch, plus one for the one-based day
  localparam logic [DAYS_W-1:0] EPOCH_DAY_ADJ = DAYS_W'(719162 + 1);
  localparam logic [EPOCH_W-1:0] SECS_PER_DAY = EPOCH_W'(3600 * 24);
  localparam logic [TOD_W-1:0]  SECS_PER_HOUR = TOD_W'(3600);
  localparam logic [TOD_W-1:0]  SECS_PER_MIN  = TOD_W'(60);

  // floor(u / 3) = (u * 683) >> 11 for u up to 1024; bias 171 = 513 / 3
  localparam int DIV3_W = 11;
  localparam logic [DIV3_W-1:0] DIV3_MUL   = DIV3_W'(683);
  localparam int                DIV3_SHIFT = 11;
  localparam logic [DIV3_W-1:0] DIV3_OFS   = DIV3_W'(513);
  localparam logic [ROLL_W-1:0] DIV3_BIAS  = ROLL_W'(171);

  // floor(u / 25) = (u * 5243) >> 17 for u below 8192; bias 65 = 1625 / 25
  localparam logic [X_W-1:0]   DIV25_MUL   = X_W'(5243);
  localparam int               DIV25_SHIFT = 17;
  localparam logic [X_W-1:0]   DIV25_OFS   = X_W'(1625);
  localparam logic [Q25_W-1:0] DIV25_BIAS  = Q25_W'(65);
  localparam logic [X_W-1:0]   CENT_QUART  = X_W'(25);
  localparam logic [4:0]       CENT_LAST_R = 5'd24;

  // Load enables for the front stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } ucte_adv_t;

  // Days before the first of the month, common year; leap adds one from March
  function automatic logic [CUM_W-1:0] cum_days(input logic leap,
                                                input logic [MON_W-1:0] mon);
    logic [CUM_W-1:0] base;
    case (mon)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + CUM_W'(leap && (mon >= 4'd2));
  endfunction

endpackage

@@ hw/rtl/utc_calendar_to_epoch_seconds.sv @@
// ----------------------------------------------------------------------------
// UTC calendar to epoch seconds
// Converts a broken-down UTC date and time into signed Unix seconds.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (cal_valid / cal_stall) carries one date per transaction:
//   year minus 1900, zero-based month (any value, rolled into the year),
//   day, hour, minute and second, the last four added linearly.
//   Output channel (sec_valid / sec_stall) returns one epoch_seconds value
//   per input transaction, in order.
//   The pipeline takes one transaction per cycle while cal_stall is low.
//   An accepted date passes in order through the five stages: month roll,
//   year splits, day sum, day-to-seconds multiply and final add.
//   Each stage loads when it is empty or the stage after it moves, so
//   bubbles close up. A receiver stall holds the output register and
//   backs up stage by stage; cal_stall rises only when all five are full.
//   Synchronous reset clears every valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
module utc_calendar_to_epoch_seconds (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cal_valid,
  output logic                                 cal_stall,
  input  logic signed [ucte_pkg::YEAR_W-1:0]   year_since_1900,
  input  logic signed [ucte_pkg::MONTH_W-1:0]  month_index,
  input  logic        [ucte_pkg::DAY_W-1:0]    day_of_month,
  input  logic        [ucte_pkg::HOUR_W-1:0]   hour_of_day,
  input  logic        [ucte_pkg::MIN_W-1:0]    minute_of_hour,
  input  logic        [ucte_pkg::SEC_W-1:0]    second_of_minute,
  output logic                                 sec_valid,
  input  logic                                 sec_stall,
  output logic signed [ucte_pkg::EPOCH_W-1:0]  epoch_seconds
);
  import ucte_pkg::*;

  // Stage valid bits; sec_valid is the fifth
  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4, adv5;
  ucte_adv_t adv;

  // Load enables, from the output back
  assign adv5 = !sec_valid || !sec_stall;
  assign adv4 = !v4 || adv5;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign cal_stall = !adv1;

  assign adv.s1 = adv1;
  assign adv.s2 = adv2;
  assign adv.s3 = adv3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      sec_valid <= 1'b0;
    end else begin
      if (adv1) v1        <= cal_valid;
      if (adv2) v2        <= v1;
      if (adv3) v3        <= v2;
      if (adv4) v4        <= v3;
      if (adv5) sec_valid <= v4;
    end
  end

  // Stages 1 to 3: days since epoch and time-of-day seconds
  logic [DAYS_W-1:0] s3_days;
  logic [TOD_W-1:0]  s3_tod;

  ucte_days u_days (
    .clk              (clk),
    .adv              (adv),
    .year_since_1900  (year_since_1900),
    .month_index      (month_index),
    .day_of_month     (day_of_month),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute),
    .days             (s3_days),
    .tod              (s3_tod)
  );

  // Stage 4: days times seconds per day, kept modulo the output width
  logic [EPOCH_W-1:0] day_secs;
  logic [EPOCH_W-1:0] s4_prod;
  logic [TOD_W-1:0]   s4_tod;

  assign day_secs = {{(EPOCH_W-DAYS_W){s3_days[DAYS_W-1]}}, s3_days} * SECS_PER_DAY;

  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_prod <= day_secs;
      s4_tod  <= s3_tod;
    end
  end

  // Stage 5: add time of day into the output register
  always_ff @(posedge clk) begin
    if (adv5) begin
      epoch_seconds <= s4_prod + EPOCH_W'(s4_tod);
    end
  end

endmodule

@@ hw/rtl/ucte_days.sv @@
// ----------------------------------------------------------------------------
// UTC calendar to epoch seconds: day count front end
// Three pipeline stages: month roll into year, year splits, days since epoch; also time-of-day seconds.
// ----------------------------------------------------------------------------
module ucte_days (
  input  logic                                 clk,
  input  ucte_pkg::ucte_adv_t                  adv,
  input  logic        [ucte_pkg::YEAR_W-1:0]   year_since_1900,
  input  logic        [ucte_pkg::MONTH_W-1:0]  month_index,
  input  logic        [ucte_pkg::DAY_W-1:0]    day_of_month,
  input  logic        [ucte_pkg::HOUR_W-1:0]   hour_of_day,
  input  logic        [ucte_pkg::MIN_W-1:0]    minute_of_hour,
  input  logic        [ucte_pkg::SEC_W-1:0]    second_of_minute,
  output logic        [ucte_pkg::DAYS_W-1:0]   days,
  output logic        [ucte_pkg::TOD_W-1:0]    tod
);
  import ucte_pkg::*;

  // ---------------- stage 1: month roll ----------------
  logic [MONTH_W-3:0]          m_q4;     // floor(month / 4)
  logic [DIV3_W-1:0]           u3;
  logic [2*DIV3_W-1:0]         prod3;
  logic [ROLL_W-1:0]           roll;
  logic [MON_W-1:0]            mon_n;
  logic [YR_W-1:0]             year_n;

  logic [YR_W-1:0]             s1_year;
  logic [MON_W-1:0]            s1_mon;
  logic [DAY_W-1:0]            s1_day;
  logic [HOUR_W-1:0]           s1_hour;
  logic [MIN_W-1:0]            s1_min;
  logic [SEC_W-1:0]            s1_sec;

  assign m_q4   = month_index[MONTH_W-1:2];
  assign u3     = {{(DIV3_W-MONTH_W+2){m_q4[MONTH_W-3]}}, m_q4} + DIV3_OFS;
  assign prod3  = u3 * DIV3_MUL;
  assign roll   = prod3[DIV3_SHIFT +: ROLL_W] - DIV3_BIAS;
  // low bits of month - 12 * roll, which is month + 4 * roll modulo 16
  assign mon_n  = month_index[MON_W-1:0] + {roll[1:0], 2'b00};
  assign year_n = {{(YR_W-YEAR_W){year_since_1900[YEAR_W-1]}}, year_since_1900}
                + YEAR_ORIGIN + {{(YR_W-ROLL_W){roll[ROLL_W-1]}}, roll};

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      s1_year <= year_n;
      s1_mon  <= mon_n;
      s1_day  <= day_of_month;
      s1_hour <= hour_of_day;
      s1_min  <= minute_of_hour;
      s1_sec  <= second_of_minute;
    end
  end

  // ---------------- stage 2: year - 1 splits ----------------
  logic [YR_W-1:0]             p;
  logic [X_W-1:0]              x;
  logic [X_W-1:0]              u25;
  logic [PROD25_W-1:0]         prod25;
  logic [DAYS_W-1:0]           p365;
  logic [TOD_W-1:0]            tod_n;

  logic [DAYS_W-1:0]           s2_p365;
  logic [X_W-1:0]              s2_x;
  logic [PROD25_W-1:0]         s2_prod25;
  logic [1:0]                  s2_plo;
  logic [MON_W-1:0]            s2_mon;
  logic [DAY_W-1:0]            s2_day;
  logic [TOD_W-1:0]            s2_tod;

  assign p      = s1_year - YR_W'(1);
  assign x      = p[YR_W-1:2];
  assign u25    = x + DIV25_OFS;
  assign prod25 = PROD25_W'(u25) * PROD25_W'(DIV25_MUL);
  assign p365   = {{(DAYS_W-YR_W){p[YR_W-1]}}, p} * DAYS_PER_YR;
  assign tod_n  = TOD_W'(s1_hour) * SECS_PER_HOUR + TOD_W'(s1_min) * SECS_PER_MIN
                + TOD_W'(s1_sec);

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      s2_p365   <= p365;
      s2_x      <= x;
      s2_prod25 <= prod25;
      s2_plo    <= p[1:0];
      s2_mon    <= s1_mon;
      s2_day    <= s1_day;
      s2_tod    <= tod_n;
    end
  end

  // ---------------- stage 3: leap rule and day sum ----------------
  logic [Q25_W-1:0]            q25;      // floor((year - 1) / 100)
  logic [X_W-1:0]              r25;
  logic                        cent;     // year is a multiple of 100
  logic                        leap;
  logic [DAYS_W-1:0]           days_n;

  assign q25  = s2_prod25[DIV25_SHIFT +: Q25_W] - DIV25_BIAS;
  assign r25  = s2_x - {{(X_W-Q25_W){q25[Q25_W-1]}}, q25} * CENT_QUART;
  assign cent = (s2_plo == 2'b11) && (r25[4:0] == CENT_LAST_R);
  // multiple of 4, and not a century unless a multiple of 400
  assign leap = (s2_plo == 2'b11) && (!cent || (q25[1:0] == 2'b11));

  assign days_n = s2_p365
                + {{(DAYS_W-X_W){s2_x[X_W-1]}}, s2_x}
                - {{(DAYS_W-Q25_W){q25[Q25_W-1]}}, q25}
                + {{(DAYS_W-Q25_W+2){q25[Q25_W-1]}}, q25[Q25_W-1:2]}
                + DAYS_W'(cum_days(leap, s2_mon))
                + DAYS_W'(s2_day)
                - EPOCH_DAY_ADJ;

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      days <= days_n;
      tod  <= s2_tod;
    end
  end

endmodule

@@ hw/rtl/ucte_checker.sv @@
// ----------------------------------------------------------------------------
// UTC calendar to epoch seconds: port checker
// Watches the top-level ports for stall, reset and latency behavior.
// ----------------------------------------------------------------------------
`include "utc_calendar_to_epoch_seconds_defines.svh"

module ucte_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cal_valid,
  input  logic                                 cal_stall,
  input  logic                                 sec_valid,
  input  logic                                 sec_stall,
  input  logic signed [ucte_pkg::EPOCH_W-1:0]  epoch_seconds
);

  // A stalled output transaction holds
  `UCTE_ASSERT_NXT(a_out_hold, clk, rst, sec_valid && sec_stall, sec_valid && $stable(epoch_seconds), "stalled output changed")

  // Input backs up only behind a stalled, full output
  `UCTE_ASSERT_IMP(a_stall_source, clk, rst, cal_stall, sec_valid && sec_stall, "input stalled without output stall")

  // Reset empties the pipeline
  `UCTE_ASSERT_NXT(a_reset_empty, clk, 1'b0, rst, !sec_valid, "output valid after reset")

  // Accepted input reaches the output when the receiver keeps taking
  `UCTE_ASSERT_NXT(a_latency, clk, rst, (cal_valid && !cal_stall ##1 !sec_stall ##1 !sec_stall ##1 !sec_stall ##1 !sec_stall), sec_valid, "result missing after five cycles")

endmodule

bind utc_calendar_to_epoch_seconds ucte_checker u_ucte_checker (.*);
